FILE: rtl/fcl_pkg.sv
// ----------------------------------------------------------------------------
// fcl_pkg
// Types and constants shared by the frustum cull and detail level classifier.
// ----------------------------------------------------------------------------
package fcl_pkg;

    localparam int PLANES     = 6;
    localparam int HALF_BITS  = 18;
    localparam int NORM_BITS  = 12;
    localparam int OFF_BITS   = 28;
    localparam int CFG_BITS   = 64;
    localparam int IDX_BITS   = 3;

    localparam logic [IDX_BITS-1:0] REG_VIEW    = 3'd6;
    localparam logic [IDX_BITS-1:0] REG_QUALITY = 3'd7;

    localparam logic [1:0] CAUSE_NONE   = 2'd0;
    localparam logic [1:0] CAUSE_SPHERE = 2'd1;
    localparam logic [1:0] CAUSE_BOX    = 2'd2;

    // Plane word unpacked into its fields.
    typedef struct packed {
        logic signed [NORM_BITS-1:0] nx;
        logic signed [NORM_BITS-1:0] ny;
        logic signed [NORM_BITS-1:0] nz;
        logic signed [OFF_BITS-1:0]  off;
    } t_plane;

    // Per-node flags carried down the plane chain.
    typedef struct packed {
        logic sphere_ok;
        logic box_ok;
        logic has_children;
    } t_flags;

endpackage

FILE: rtl/fcl_stream_if.sv
// ----------------------------------------------------------------------------
// fcl_stream_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface fcl_stream_if #(
    parameter int WIDTH = 8
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/fcl_plane_cell.sv
// ----------------------------------------------------------------------------
// fcl_plane_cell
// One plane of the frustum: two stage sphere and box test on a passing node.
// ----------------------------------------------------------------------------
module fcl_plane_cell #(
    parameter int COORD_BITS = 20
) (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  fcl_pkg::t_plane                       i_plane,
    input  logic signed [COORD_BITS-1:0]          i_cx,
    input  logic signed [COORD_BITS-1:0]          i_cy,
    input  logic signed [COORD_BITS-1:0]          i_cz,
    input  logic [fcl_pkg::HALF_BITS-1:0]         i_half,
    input  fcl_pkg::t_flags                       i_flags,
    output logic signed [COORD_BITS-1:0]          o_cx,
    output logic signed [COORD_BITS-1:0]          o_cy,
    output logic signed [COORD_BITS-1:0]          o_cz,
    output logic [fcl_pkg::HALF_BITS-1:0]         o_half,
    output fcl_pkg::t_flags                       o_flags
);
    // Vertex coordinates hold a centre plus or minus the half size.
    localparam int VW = ((COORD_BITS > fcl_pkg::HALF_BITS) ? COORD_BITS
                                                           : fcl_pkg::HALF_BITS) + 2;
    localparam int PW = VW + fcl_pkg::NORM_BITS;
    localparam int DW = 48;
    localparam int SW = 64;

    // Stage one: the six normal products.
    logic signed [PW-1:0] r_pc0, r_pc1, r_pc2, r_pv0, r_pv1, r_pv2;
    logic signed [COORD_BITS-1:0] r_cx, r_cy, r_cz;
    logic [fcl_pkg::HALF_BITS-1:0] r_half;
    fcl_pkg::t_flags r_flags;
    fcl_pkg::t_plane r_plane;

    logic signed [VW-1:0] hs, vx, vy, vz;
    assign hs = $signed(VW'(i_half));
    assign vx = (i_plane.nx > 0) ? VW'(i_cx) + hs : VW'(i_cx) - hs;
    assign vy = (i_plane.ny > 0) ? VW'(i_cy) + hs : VW'(i_cy) - hs;
    assign vz = (i_plane.nz > 0) ? VW'(i_cz) + hs : VW'(i_cz) - hs;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pc0 <= PW'(i_plane.nx) * PW'(i_cx);
            r_pc1 <= PW'(i_plane.ny) * PW'(i_cy);
            r_pc2 <= PW'(i_plane.nz) * PW'(i_cz);
            r_pv0 <= PW'(i_plane.nx) * PW'(vx);
            r_pv1 <= PW'(i_plane.ny) * PW'(vy);
            r_pv2 <= PW'(i_plane.nz) * PW'(vz);
            r_cx <= i_cx; r_cy <= i_cy; r_cz <= i_cz;
            r_half <= i_half; r_flags <= i_flags; r_plane <= i_plane;
        end
    end

    // Stage two: distance sums and the two comparisons.
    logic signed [DW-1:0] off_s, dc, dv;
    logic signed [SW-1:0] lhs, rad;
    assign off_s = DW'(r_plane.off) <<< 10;
    assign dc = off_s + DW'(r_pc0) + DW'(r_pc1) + DW'(r_pc2);
    assign dv = off_s + DW'(r_pv0) + DW'(r_pv1) + DW'(r_pv2);
    assign lhs = SW'(dc) * 64'sd1000;
    assign rad = $signed({46'b0, r_half}) * 64'sd1773568;

    fcl_pkg::t_flags n_flags;
    always_comb begin
        n_flags = r_flags;
        if (lhs < -rad) n_flags.sphere_ok = 1'b0;
        if (dv < 0) n_flags.box_ok = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cx <= r_cx; o_cy <= r_cy; o_cz <= r_cz;
            o_half <= r_half; o_flags <= n_flags;
        end
    end
endmodule

FILE: rtl/fcl_lod_unit.sv
// ----------------------------------------------------------------------------
// fcl_lod_unit
// Distance squared against thresholds, in step with the plane chain.
// ----------------------------------------------------------------------------
module fcl_lod_unit #(
    parameter int COORD_BITS = 20,
    parameter int DEPTH      = 12
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_BITS-1:0]  i_cx,
    input  logic signed [COORD_BITS-1:0]  i_cy,
    input  logic signed [COORD_BITS-1:0]  i_cz,
    input  logic [fcl_pkg::HALF_BITS-1:0] i_half,
    input  logic [3*COORD_BITS-1:0]       i_view,
    input  logic [15:0]                   i_quality,
    output logic [2:0]                    o_lod
);
    // Stage one: deltas and half times quality.
    logic [COORD_BITS:0] r_a0, r_a1, r_a2;
    logic [33:0] r_hq;
    logic signed [COORD_BITS:0] d0, d1, d2;
    assign d0 = i_cx - $signed(i_view[3*COORD_BITS-1:2*COORD_BITS]);
    assign d1 = i_cy - $signed(i_view[2*COORD_BITS-1:COORD_BITS]);
    assign d2 = i_cz - $signed(i_view[COORD_BITS-1:0]);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a0 <= d0[COORD_BITS] ? COORD_BITS'(0) - d0 : d0;
            r_a1 <= d1[COORD_BITS] ? COORD_BITS'(0) - d1 : d1;
            r_a2 <= d2[COORD_BITS] ? COORD_BITS'(0) - d2 : d2;
            r_hq <= 34'(i_half) * 34'(i_quality);
        end
    end

    // Stage two: squares and threshold scaling.
    localparam int QW = 2*COORD_BITS + 2;
    logic [QW-1:0] r_s0, r_s1, r_s2;
    logic [44:0] r_m0, r_m1, r_m2, r_m3;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0 <= QW'(r_a0) * QW'(r_a0); r_s1 <= QW'(r_a1) * QW'(r_a1);
            r_s2 <= QW'(r_a2) * QW'(r_a2);
            r_m0 <= 45'(r_hq) * 45'd50;  r_m1 <= 45'(r_hq) * 45'd200;
            r_m2 <= 45'(r_hq) * 45'd500; r_m3 <= 45'(r_hq) * 45'd2000;
        end
    end

    // Stage three: sum and saturating squares of the thresholds.
    logic [63:0] r_d2s;
    logic [63:0] r_q0, r_q1, r_q2, r_q3;
    logic [3:0] r_big;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d2s <= (64'(r_s0) + 64'(r_s1) + 64'(r_s2)) << 16;
            r_q0 <= 64'(r_m0[31:0]) * 64'(r_m0[31:0]);
            r_q1 <= 64'(r_m1[31:0]) * 64'(r_m1[31:0]);
            r_q2 <= 64'(r_m2[31:0]) * 64'(r_m2[31:0]);
            r_q3 <= 64'(r_m3[31:0]) * 64'(r_m3[31:0]);
            r_big <= {|r_m3[44:32], |r_m2[44:32], |r_m1[44:32], |r_m0[44:32]};
        end
    end

    // Stage four: level select; then a delay line to meet the chain.
    logic [3:0] below;
    assign below[0] = r_big[0] || (r_d2s < r_q0);
    assign below[1] = r_big[1] || (r_d2s < r_q1);
    assign below[2] = r_big[2] || (r_d2s < r_q2);
    assign below[3] = r_big[3] || (r_d2s < r_q3);
    logic [2:0] lvl;
    always_comb begin
        if (below[0]) lvl = 3'd0;
        else if (below[1]) lvl = 3'd1;
        else if (below[2]) lvl = 3'd2;
        else if (below[3]) lvl = 3'd3;
        else lvl = 3'd4;
    end

    localparam int TAPS = DEPTH - 3;
    logic [2:0] r_dl [TAPS];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dl[0] <= lvl;
            for (int k = 1; k < TAPS; k++) r_dl[k] <= r_dl[k-1];
        end
    end
    assign o_lod = r_dl[TAPS-1];
endmodule

FILE: rtl/frustum_cull_lod_classifier.sv
// ----------------------------------------------------------------------------
// frustum_cull_lod_classifier
// Plane test chain of six cells plus a detail level unit, one node a cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Latency: 13 register stages (two per plane cell, one output register).
// Throughput: one node per cycle; the chain stalls as a whole only when the
// result register is full and not taken while the last chain stage holds a
// node.
// Reset: synchronous, active low; clears valid bits, planes and viewer to
// zero and the quality factor to 1.0.
module frustum_cull_lod_classifier #(
    parameter int COORD_BITS = 20,
    parameter int PLANE_COUNT = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [fcl_pkg::IDX_BITS-1:0] i_cfg_idx,
    input  logic [fcl_pkg::CFG_BITS-1:0] i_cfg_data,
    fcl_stream_if.sink   s_in,
    fcl_stream_if.source m_out
);
    localparam int DEPTH = 2 * PLANE_COUNT;

    // Configuration registers.
    logic [fcl_pkg::CFG_BITS-1:0] r_plane [PLANE_COUNT];
    logic [3*COORD_BITS-1:0] r_view;
    logic [15:0] r_quality;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PLANE_COUNT; k++) r_plane[k] <= '0;
            r_view <= '0;
            r_quality <= 16'd256;
        end else if (i_cfg_we) begin
            if (32'(i_cfg_idx) < PLANE_COUNT) r_plane[i_cfg_idx] <= i_cfg_data;
            else if (i_cfg_idx == fcl_pkg::REG_VIEW) r_view <= i_cfg_data[3*COORD_BITS-1:0];
            else if (i_cfg_idx == fcl_pkg::REG_QUALITY) r_quality <= i_cfg_data[15:0];
        end
    end

    // Chain valid bits, output register enable and global chain enable.
    logic [DEPTH-1:0] r_vld;
    logic r_ovld;
    logic out_en;
    logic en;
    assign out_en = !r_ovld || m_out.ready;
    assign en = !r_vld[DEPTH-1] || out_en;
    assign s_in.ready = en;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (en) r_vld <= {r_vld[DEPTH-2:0], s_in.valid};
    end

    // Unpack input word: cx, cy, cz, half, has_children.
    logic signed [COORD_BITS-1:0] cx [PLANE_COUNT+1];
    logic signed [COORD_BITS-1:0] cy [PLANE_COUNT+1];
    logic signed [COORD_BITS-1:0] cz [PLANE_COUNT+1];
    logic [fcl_pkg::HALF_BITS-1:0] hf [PLANE_COUNT+1];
    fcl_pkg::t_flags fl [PLANE_COUNT+1];
    assign cx[0] = s_in.data[3*COORD_BITS+fcl_pkg::HALF_BITS:2*COORD_BITS+fcl_pkg::HALF_BITS+1];
    assign cy[0] = s_in.data[2*COORD_BITS+fcl_pkg::HALF_BITS:COORD_BITS+fcl_pkg::HALF_BITS+1];
    assign cz[0] = s_in.data[COORD_BITS+fcl_pkg::HALF_BITS:fcl_pkg::HALF_BITS+1];
    assign hf[0] = s_in.data[fcl_pkg::HALF_BITS:1];
    assign fl[0] = '{sphere_ok: 1'b1, box_ok: 1'b1, has_children: s_in.data[0]};

    for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_cell
        fcl_plane_cell #(.COORD_BITS(COORD_BITS)) u_cell (
            .i_clk(i_clk), .i_en(en), .i_plane(fcl_pkg::t_plane'(r_plane[g])),
            .i_cx(cx[g]), .i_cy(cy[g]), .i_cz(cz[g]), .i_half(hf[g]), .i_flags(fl[g]),
            .o_cx(cx[g+1]), .o_cy(cy[g+1]), .o_cz(cz[g+1]), .o_half(hf[g+1]),
            .o_flags(fl[g+1])
        );
    end

    logic [2:0] lod;
    fcl_lod_unit #(.COORD_BITS(COORD_BITS), .DEPTH(DEPTH)) u_lod (
        .i_clk(i_clk), .i_en(en), .i_cx(cx[0]), .i_cy(cy[0]), .i_cz(cz[0]),
        .i_half(hf[0]), .i_view(r_view), .i_quality(r_quality), .o_lod(lod)
    );

    // Result word: visible, cause, level, leaf.
    fcl_pkg::t_flags f;
    logic vis;
    logic [1:0] cause;
    logic [2:0] lv;
    assign f = fl[PLANE_COUNT];
    assign cause = !f.sphere_ok ? fcl_pkg::CAUSE_SPHERE :
                   !f.box_ok ? fcl_pkg::CAUSE_BOX : fcl_pkg::CAUSE_NONE;
    assign vis = (cause == fcl_pkg::CAUSE_NONE);
    assign lv = vis ? lod : 3'd0;

    // The output register loads only when it is empty or being taken.
    logic [6:0] r_odata;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovld <= 1'b0;
        else if (out_en) r_ovld <= r_vld[DEPTH-1];
        if (out_en) r_odata <= {vis, cause, lv, vis && (!f.has_children || lv >= 3'd3)};
    end
    assign m_out.valid = r_ovld;
    assign m_out.data = r_odata;
endmodule

FILE: rtl/fcl_checker.sv
// ----------------------------------------------------------------------------
// fcl_checker
// Port level checks on the classifier result stream.
// ----------------------------------------------------------------------------
module fcl_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [6:0] i_out_data
);
    // No result word is offered right after a reset cycle.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid) else $error("reset");
    // Visible results carry no cause; culled results carry level zero.
    a_vis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data[6] |-> i_out_data[5:4] == 2'd0) else $error("cause");
    a_cull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data[6] |-> i_out_data[3:1] == 3'd0 && !i_out_data[0])
        else $error("culled");
    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data)) else $error("hold");
endmodule

bind frustum_cull_lod_classifier fcl_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_ready(s_in.ready),
    .i_out_valid(m_out.valid), .i_out_ready(m_out.ready), .i_out_data(m_out.data)
);
